>>> rtl/tavp_pkg.sv
// Package for the three-axis velocity PID: widths, register indexes, helpers.
// No dependencies.
package tavp_pkg;
  localparam int DW = 16;
  localparam int AW = 40;
  localparam int RW = 48;
  localparam int NREG = 7;
  localparam int SW = 17;

  typedef enum logic [2:0] {
    REG_KP = 3'd0, REG_KI = 3'd1, REG_KD = 3'd2, REG_IL = 3'd3,
    REG_AL = 3'd4, REG_FL = 3'd5, REG_FF = 3'd6
  } reg_idx_t;

  localparam logic [SW-1:0] STEP_FALLBACK = 17'd655;
  localparam logic [SW-1:0] STEP_ONE = 17'd65536;

  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  // Divider control between sequencer and divider.
  typedef struct packed {
    logic start;
    logic signed [40:0] num;
    logic [SW-1:0] den;
  } div_req_t;

  function automatic logic signed [AW-1:0] sat_acc(input logic signed [63:0] x);
    if (x > 64'(ACC_MAX)) return ACC_MAX;
    else if (x < 64'(ACC_MIN)) return ACC_MIN;
    else return x[AW-1:0];
  endfunction
endpackage

>>> rtl/three_axis_velocity_pid.sv
// Top level of the three-axis velocity PID: registers, sequencer, datapath.
// Depends on tavp_pkg and tavp_div.
//
//  channel  | handshake                    | payload
//  in       | in_valid / in_ready          | req_type, target_*, meas_*, step_time
//  out      | out_valid / out_ready        | drive_x, drive_y, drive_z
//  cfg      | cfg_we                       | cfg_index, cfg_data
//
// An update runs per axis through one integrate state, a divide state that waits
// for the 41-step serial divide, four multiply-accumulate steps on one shared
// multiplier and one finish state, for x, y and z in turn.
// With no derivative (first update after reset or a clear) the divide is skipped.
// A clear item is answered straight from idle.
// rst clears state, integrals, history and the handshake.
// The result waits in an output register; the next item is taken once it is
// transferred.
module three_axis_velocity_pid import tavp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic signed [DW-1:0] target_x,
  input  logic signed [DW-1:0] target_y,
  input  logic signed [DW-1:0] target_z,
  input  logic signed [DW-1:0] meas_x,
  input  logic signed [DW-1:0] meas_y,
  input  logic signed [DW-1:0] meas_z,
  input  logic [SW-1:0] step_time,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [DW-1:0] drive_x,
  output logic signed [DW-1:0] drive_y,
  output logic signed [DW-1:0] drive_z,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [RW-1:0] cfg_data
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_INT = 8'b00000010, S_DIV = 8'b00000100,
    S_M0 = 8'b00001000, S_M1 = 8'b00010000, S_M2 = 8'b00100000,
    S_M3 = 8'b01000000, S_FIN = 8'b10000000
  } state_t;

  logic [RW-1:0] regs [NREG];
  logic signed [AW-1:0] integ_acc [3];
  logic signed [DW:0] last_error [3];
  logic primed;
  state_t state;
  logic [1:0] axis;
  logic signed [DW-1:0] tgt [3];
  logic signed [DW-1:0] mea [3];
  logic [SW-1:0] dt;
  logic signed [DW-1:0] drv [3];
  logic signed [DW:0] err;
  logic signed [AW-1:0] integ, deriv, sq;
  logic signed [63:0] sum;
  div_req_t dreq;
  logic dbusy;
  logic signed [40:0] dq;

  // Shared multiplier: signed operand by unsigned 17-bit factor.
  logic signed [AW:0] ma;
  logic signed [SW:0] mb;
  logic signed [63:0] prod;
  assign prod = 64'(ma) * 64'(mb);

  tavp_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quo(dq));

  function automatic logic [15:0] fld(input logic [RW-1:0] r, input logic [1:0] a);
    return r[16*a +: 16];
  endfunction

  function automatic logic signed [63:0] fshift(input logic signed [63:0] x,
                                                input int s);
    return x >>> s;
  endfunction

  logic signed [DW-1:0] t_cur;
  logic [15:0] lim;
  logic signed [63:0] il64, raw;
  assign t_cur = tgt[axis];
  assign err = 17'(tgt[axis]) - 17'(mea[axis]);
  assign il64 = 64'(fld(regs[REG_IL], axis)) <<< 16;
  assign lim = (fld(regs[REG_AL], axis) != 16'd0) ? fld(regs[REG_AL], axis)
                                                  : fld(regs[REG_FL], axis);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_INT: begin ma = 41'(err); mb = {1'b0, dt}; end
      S_DIV: begin ma = 41'(t_cur); mb = t_cur[DW-1] ? -18'(t_cur) : 18'(t_cur); end
      S_M0: begin ma = 41'(err); mb = {2'b0, fld(regs[REG_KP], axis)}; end
      S_M1: begin ma = 41'(integ); mb = {2'b0, fld(regs[REG_KI], axis)}; end
      S_M2: begin ma = 41'(deriv); mb = {2'b0, fld(regs[REG_KD], axis)}; end
      S_M3: begin ma = 41'(sq); mb = {2'b0, fld(regs[REG_FF], axis)}; end
      default: ;
    endcase
  end

  always_comb begin
    raw = fshift(sum + 64'sd128, 8);
    if (lim != 16'd0) begin
      if (raw > $signed(64'(lim))) raw = $signed(64'(lim));
      else if (raw < -$signed(64'(lim))) raw = -$signed(64'(lim));
    end
    if (raw > 64'sd32767) raw = 64'sd32767;
    else if (raw < -64'sd32768) raw = -64'sd32768;
  end

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign drive_x = drv[0];
  assign drive_y = drv[1];
  assign drive_z = drv[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) regs[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        integ_acc[i] <= '0;
        last_error[i] <= '0;
      end
      primed <= 1'b0;
      state <= S_IDLE;
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      if (cfg_we && cfg_index < 3'(NREG)) regs[cfg_index] <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          tgt[0] <= target_x; tgt[1] <= target_y; tgt[2] <= target_z;
          mea[0] <= meas_x; mea[1] <= meas_y; mea[2] <= meas_z;
          dt <= (step_time == '0 || step_time > STEP_ONE) ? STEP_FALLBACK : step_time;
          axis <= 2'd0;
          if (req_type) begin
            // Clear: drop history and answer zero.
            for (int i = 0; i < 3; i++) begin
              integ_acc[i] <= '0;
              last_error[i] <= '0;
              drv[i] <= '0;
            end
            primed <= 1'b0;
            out_valid <= 1'b1;
          end else begin
            state <= S_INT;
          end
        end
        S_INT: begin
          integ <= sat_acc(64'(integ_acc[axis]) + prod);
          dreq.num <= (41'(err) - 41'(last_error[axis])) <<< 16;
          dreq.den <= dt;
          dreq.start <= primed;
          state <= S_DIV;
        end
        S_DIV: begin
          // Start is a one-cycle pulse: drop it on the first divide cycle.
          dreq.start <= 1'b0;
          if (fld(regs[REG_IL], axis) != 16'd0) begin
            if (64'(integ) > il64) integ <= il64[AW-1:0];
            else if (64'(integ) < -il64) integ <= 40'(-il64);
          end
          sq <= sat_acc(prod);
          if (!dreq.start && !dbusy) begin
            deriv <= primed ? dq[AW-1:0] : '0;
            state <= S_M0;
          end
        end
        S_M0: begin sum <= prod; state <= S_M1; end
        S_M1: begin sum <= sum + fshift(prod, 16); state <= S_M2; end
        S_M2: begin sum <= sum + prod; state <= S_M3; end
        S_M3: begin sum <= sum + fshift(prod, 8); state <= S_FIN; end
        S_FIN: begin
          drv[axis] <= raw[DW-1:0];
          integ_acc[axis] <= integ;
          last_error[axis] <= err;
          if (axis == 2'd2) begin
            primed <= 1'b1;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            axis <= axis + 2'd1;
            state <= S_INT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !dbusy) else $error("divider busy in idle");
  a_out_after_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && axis == 2'd2) |=> out_valid) else $error("result lost");
endmodule

>>> rtl/tavp_div.sv
// Serial restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on tavp_pkg.
module tavp_div import tavp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_req_t req,
  output logic busy,
  output logic signed [40:0] quo
);
  logic [40:0] mag;
  logic [40:0] q;
  logic [SW:0] rem;
  logic [SW-1:0] den;
  logic neg;
  logic [5:0] cnt;
  logic [SW:0] trial;

  assign trial = {rem[SW-1:0], mag[40]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 6'd41;
      neg <= req.num[40];
      mag <= req.num[40] ? 41'(-req.num) : req.num;
      rem <= '0;
      den <= req.den;
      q <= '0;
    end else if (busy) begin
      mag <= {mag[39:0], 1'b0};
      if (!trial[SW]) begin
        rem <= trial;
        q <= {q[39:0], 1'b1};
      end else begin
        rem <= {rem[SW-1:0], mag[40]};
        q <= {q[39:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  assign quo = neg ? 41'(-q) : q;
endmodule

>>> bench/three_axis_velocity_pid_test.sv
// Self-checking bench for three_axis_velocity_pid: random and directed updates,
// clears and register settings, checked against an in-bench fixed-point model.
// Depends on tavp_pkg and the RTL of three_axis_velocity_pid.
module three_axis_velocity_pid_test;
  import tavp_pkg::*;

  typedef logic [2:0][DW-1:0] axis_set_t;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 500;

  // Fixed-point model of the controller plus the queue of predicted drives.
  class pid_scoreboard;
    logic [RW-1:0] regs [NREG];
    longint integ [3];
    longint last_err [3];
    bit primed;
    axis_set_t drives_due [$];
    int mismatches;

    function new();
      for (int i = 0; i < NREG; i++) regs[i] = '0;
      for (int a = 0; a < 3; a++) begin
        integ[a] = 0;
        last_err[a] = 0;
      end
      primed = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [RW-1:0] data);
      if (idx < NREG) regs[idx] = data;
    endfunction

    function longint sat(longint x, int w);
      longint hi;
      hi = (64'sd1 <<< (w - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
    endfunction

    function longint clamp_sym(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    function longint field(int r, int a);
      logic [15:0] f;
      f = regs[r][16*a +: 16];
      return longint'({48'd0, f});
    endfunction

    // Advance the controller state by one accepted item and queue its drive.
    function void note_item(logic req, axis_set_t tgt, axis_set_t meas,
                            logic [SW-1:0] st);
      axis_set_t drv;
      longint dt, t, e, ig, dv, sq, sum, raw, il, lim;
      drv = '0;
      if (req == REQ_CLEAR) begin
        for (int a = 0; a < 3; a++) begin
          integ[a] = 0;
          last_err[a] = 0;
        end
        primed = 0;
        drives_due.push_back(drv);
        return;
      end
      dt = (st == 0 || st > STEP_ONE) ? longint'(STEP_FALLBACK) : longint'(st);
      for (int a = 0; a < 3; a++) begin
        t = longint'($signed(tgt[a]));
        e = t - longint'($signed(meas[a]));
        ig = sat(integ[a] + e * dt, AW);
        il = field(REG_IL, a);
        if (il != 0) ig = clamp_sym(ig, il * 65536);
        dv = primed ? sat(((e - last_err[a]) * 65536) / dt, AW) : 0;
        sq = sat(t * (t < 0 ? -t : t), AW);
        sum = field(REG_KP, a) * e + ((field(REG_KI, a) * ig) >>> 16)
            + field(REG_KD, a) * dv + ((field(REG_FF, a) * sq) >>> 8);
        raw = (sum + 128) >>> 8;
        lim = field(REG_AL, a) != 0 ? field(REG_AL, a) : field(REG_FL, a);
        if (lim != 0) raw = clamp_sym(raw, lim);
        raw = sat(raw, DW);
        integ[a] = ig;
        last_err[a] = e;
        drv[a] = raw[DW-1:0];
      end
      primed = 1;
      drives_due.push_back(drv);
    endfunction

    function void check_drive(axis_set_t got);
      axis_set_t want;
      if (drives_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected drive transfer: x=%0d y=%0d z=%0d",
                   $signed(got[0]), $signed(got[1]), $signed(got[2]));
        return;
      end
      want = drives_due.pop_front();
      for (int a = 0; a < 3; a++) begin
        if (got[a] !== want[a]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive axis %0d mismatch: expected %0d, got %0d",
                     a, $signed(want[a]), $signed(got[a]));
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic req_type = REQ_UPDATE;
  logic signed [DW-1:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [DW-1:0] meas_x = '0, meas_y = '0, meas_z = '0;
  logic [SW-1:0] step_time = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [DW-1:0] drive_x, drive_y, drive_z;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [RW-1:0] cfg_data = '0;

  pid_scoreboard sb = new();
  bit tx_steady = 0;   // sender runs without gaps
  bit rx_steady = 0;   // receiver starts no new stalls
  int idle_cycles = 0;

  three_axis_velocity_pid dut (.*);

  always #4 clk = ~clk;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Hold valid with a steady payload until the transfer, then note it.
  task automatic send_item(logic req, axis_set_t tgt, axis_set_t meas,
                           logic [SW-1:0] st);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    req_type = req;
    {target_z, target_y, target_x} = tgt;
    {meas_z, meas_y, meas_x} = meas;
    step_time = st;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(req, tgt, meas, st);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted drive has come back.
  task automatic drain();
    in_valid = 0;
    while (sb.drives_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [RW-1:0] data);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [15:0] rand_gain_field(int style);
    case (style)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  // Pick a whole register set in one style, or styles mixed per field for style 4; one style per phase.
  task automatic load_regs(int style);
    logic [RW-1:0] d;
    write_reg(REG_UNUSED, {RW{1'b1}});
    for (int r = 0; r < NREG; r++) begin
      for (int a = 0; a < 3; a++)
        d[16*a +: 16] = (style < 4) ? rand_gain_field(style)
                                    : rand_gain_field($urandom_range(0, 3));
      write_reg(3'(r), d);
    end
  endtask

  function automatic logic [DW-1:0] rand_vel();
    if ($urandom_range(0, 3) == 0) return DW'($urandom);
    return DW'($urandom_range(0, 4095)) - DW'(2048);
  endfunction

  function automatic logic [SW-1:0] rand_step();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return SW'($urandom_range(65537, 131071));
    if (r < 6) return SW'($urandom);
    return SW'($urandom_range(1, 65536));
  endfunction

  task automatic send_random();
    axis_set_t tgt, meas;
    for (int a = 0; a < 3; a++) begin
      tgt[a] = rand_vel();
      meas[a] = rand_vel();
    end
    send_item(($urandom_range(0, 19) == 0) ? REQ_CLEAR : REQ_UPDATE,
              tgt, meas, rand_step());
  endtask

  // Receiver: random stalls, with steady stretches when rx_steady is set.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready = 0;
      end else begin
        out_ready = 1;
        if (!rx_steady && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_drive({drive_z, drive_y, drive_x});
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    axis_set_t pos_max, neg_max, zero_v;
    pos_max = {3{16'sh7FFF}};
    neg_max = {3{16'sh8000}};
    zero_v = '0;
    repeat (4) @(negedge clk);
    rst = 0;

    // Directed part: registers still at reset, then a mixed setting.
    send_item(REQ_UPDATE, pos_max, neg_max, 17'd0);
    drain();
    load_regs(4);
    send_item(REQ_CLEAR, pos_max, neg_max, 17'd1);
    send_item(REQ_UPDATE, pos_max, neg_max, 17'd1);
    send_item(REQ_UPDATE, neg_max, pos_max, 17'd1);
    send_item(REQ_UPDATE, neg_max, pos_max, STEP_ONE);
    send_item(REQ_UPDATE, zero_v, zero_v, STEP_ONE + 17'd1);
    send_item(REQ_UPDATE, pos_max, zero_v, 17'h1FFFF);
    send_item(REQ_CLEAR, zero_v, zero_v, 17'd0);
    send_item(REQ_UPDATE, {16'sh0100, 16'shFF00, 16'sh0001},
              {16'shFF00, 16'sh0100, 16'sh0000}, 17'd655);
    drain();
    load_regs(1);   // every field at its maximum
    for (int i = 0; i < 4; i++) send_item(REQ_UPDATE, pos_max, neg_max, 17'd1);
    for (int i = 0; i < 3; i++) send_item(REQ_UPDATE, neg_max, pos_max, 17'd1);
    send_item(REQ_UPDATE, {16'h5555, 16'hAAAA, 16'h0F0F},
              {16'hAAAA, 16'h5555, 16'hF0F0}, 17'h15555);
    drain();
    load_regs(0);   // all zero: no clamps, no gains
    send_item(REQ_UPDATE, pos_max, neg_max, 17'd300);
    send_item(REQ_UPDATE, neg_max, pos_max, 17'h0AAAA);

    // Random part in phases, each with its own register setting.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        drain();
        load_regs(n == 0 ? 2 : (n == 300 ? 1 : $urandom_range(2, 4)));
        tx_steady = (n == 200);
        rx_steady = (n == 100 || n == 200);
      end else if (n % 37 == 0) drain();
      send_random();
    end
    in_valid = 0;

    while (sb.drives_due.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.mismatches == 0 && sb.drives_due.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
